### rtl/fcp_pkg.sv
`default_nettype none

package fcp_pkg;

    localparam int unsigned MAX_FRAME_BYTES_DEF = 256;

    localparam logic [7:0] CH_OPEN  = 8'h24;
    localparam logic [7:0] CH_CLOSE = 8'h23;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [15:0] MAG_SAT = 16'd32768;
    localparam logic [15:0] POS_MAX = 16'd32767;

    typedef enum logic [1:0] {
        ST_UPDATED    = 2'd0,
        ST_BAD_PREFIX = 2'd1,
        ST_MISSING    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_SIGNED = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

endpackage

`default_nettype wire

### rtl/framed_coordinate_parser_top.sv
`default_nettype none

// Byte-serial parser for "$LXY?<x>,<y>#" frames. One received byte is taken per
// beat and a new beat can be accepted every cycle; each byte is registered, then
// decoded against the frame state; a closing '#' has its result registered as an
// output beat. Input is held off only while a finished result waits on a stalled
// output and the byte in hand would close another frame. Each closed frame gives
// one result: status 0 with the new coordinates, 1 for a bad or
// short "LXY" prefix, 2 when fewer than two numbers were found; on 1 or 2 the held
// coordinates are reported unchanged. Frames longer than MAX_FRAME_BYTES data
// bytes are dropped with no result. Numbers are read atoi style and saturate to
// 16 bits.
module framed_coordinate_parser_top
    import fcp_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [7:0]         i_rx_byte,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [1:0]              o_frame_status,
    output logic signed [15:0]      o_pos_x,
    output logic signed [15:0]      o_pos_y
);

    localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FRAME_BYTES);
    localparam logic [CW-1:0] POS_SKIP = CW'(3);

    logic               r_in_vld;
    logic [7:0]         r_in_byte;

    logic               r_in_frame, n_in_frame;
    logic [CW-1:0]      r_count, n_count;
    logic               r_prefix_good, n_prefix_good;
    logic               r_text_ended, n_text_ended;
    logic [1:0]         r_tok_num, n_tok_num;
    logic               r_inside, n_inside;
    t_phase             r_phase, n_phase;
    logic               r_neg, n_neg;
    logic [15:0]        r_mag, n_mag;
    logic [15:0]        r_first, n_first;
    logic [15:0]        r_held_x, n_held_x;
    logic [15:0]        r_held_y, n_held_y;

    logic               r_out_vld;
    t_status            r_out_status, n_out_status;
    logic [15:0]        r_out_x;
    logic [15:0]        r_out_y;

    logic               closing;
    logic               out_free;
    logic               advance;
    logic               emit;

    logic [15:0]        tok_val;
    logic [1:0]         fin_tok_num;
    logic [15:0]        fin_first;

    function automatic logic [15:0] value_of(input logic neg, input logic [15:0] mag);
        logic [15:0] v;
        if (neg) begin
            v = 16'(-mag);
        end else if (mag > POS_MAX) begin
            v = POS_MAX;
        end else begin
            v = mag;
        end
        return v;
    endfunction

    assign closing  = r_in_vld && r_in_frame && (r_in_byte == CH_CLOSE);
    assign out_free = !r_out_vld || !i_stall;
    assign advance  = r_in_vld && (!closing || out_free);
    assign emit     = advance && closing;
    assign o_stall  = r_in_vld && !advance;

    assign tok_val     = value_of(r_neg, r_mag);
    assign fin_tok_num = (r_inside && (r_tok_num < 2'd2)) ? r_tok_num + 2'd1 : r_tok_num;
    assign fin_first   = (r_inside && (r_tok_num == 2'd0)) ? tok_val : r_first;

    always_comb begin
        logic [7:0]  c;
        t_phase      ph;
        logic        ng;
        logic [15:0] mg;
        logic [19:0] prod;
        logic        clear;

        c    = r_in_byte;
        ph   = r_phase;
        ng   = r_neg;
        mg   = r_mag;
        prod = '0;
        clear = 1'b0;

        n_in_frame    = r_in_frame;
        n_count       = r_count;
        n_prefix_good = r_prefix_good;
        n_text_ended  = r_text_ended;
        n_tok_num     = r_tok_num;
        n_inside      = r_inside;
        n_phase       = r_phase;
        n_neg         = r_neg;
        n_mag         = r_mag;
        n_first       = r_first;
        n_held_x      = r_held_x;
        n_held_y      = r_held_y;
        n_out_status  = ST_UPDATED;

        if (!r_in_frame) begin
            if (c == CH_OPEN) begin
                n_in_frame = 1'b1;
                clear      = 1'b1;
            end
        end else if (c != CH_CLOSE) begin
            if (r_count >= CNT_MAX) begin
                n_in_frame = 1'b0;
                clear      = 1'b1;
            end else begin
                n_count = r_count + CW'(1);
                if (r_count < POS_SKIP) begin
                    case (r_count[1:0])
                        2'd0:    if (c != CH_L) n_prefix_good = 1'b0;
                        2'd1:    if (c != CH_X) n_prefix_good = 1'b0;
                        default: if (c != CH_Y) n_prefix_good = 1'b0;
                    endcase
                end else if (!r_text_ended) begin
                    if (c == CH_NUL) begin
                        n_text_ended = 1'b1;
                        n_tok_num    = fin_tok_num;
                        n_first      = fin_first;
                        n_inside     = 1'b0;
                    end else if (r_count == POS_SKIP) begin
                        n_count = r_count + CW'(1);
                    end else if (c == CH_COMMA || c == CH_SPACE) begin
                        n_tok_num = fin_tok_num;
                        n_first   = fin_first;
                        n_inside  = 1'b0;
                    end else if (r_tok_num < 2'd2) begin
                        if (!r_inside) begin
                            ph = PH_START;
                            ng = 1'b0;
                            mg = '0;
                        end
                        n_inside = 1'b1;
                        if (ph == PH_START && c inside {[CH_TAB:CH_CR]}) begin
                            ph = PH_START;
                        end else if (ph == PH_START && (c == CH_PLUS || c == CH_MINUS)) begin
                            ng = (c == CH_MINUS);
                            ph = PH_SIGNED;
                        end else if (ph != PH_DONE) begin
                            if (c inside {[CH_ZERO:CH_NINE]}) begin
                                prod = {1'b0, mg, 3'b000} + {3'b000, mg, 1'b0}
                                     + {16'd0, c[3:0]};
                                mg   = (prod > {4'd0, MAG_SAT}) ? MAG_SAT : prod[15:0];
                                ph   = PH_DIGITS;
                            end else begin
                                ph = PH_DONE;
                            end
                        end
                        n_phase = ph;
                        n_neg   = ng;
                        n_mag   = mg;
                    end
                end
            end
        end else begin
            n_in_frame = 1'b0;
            clear      = 1'b1;
            if ((r_count < POS_SKIP) || !r_prefix_good) begin
                n_out_status = ST_BAD_PREFIX;
            end else if (fin_tok_num < 2'd2) begin
                n_out_status = ST_MISSING;
            end else begin
                n_out_status = ST_UPDATED;
                n_held_x     = fin_first;
                n_held_y     = tok_val;
            end
        end

        if (clear) begin
            n_count       = '0;
            n_prefix_good = 1'b1;
            n_text_ended  = 1'b0;
            n_tok_num     = 2'd0;
            n_inside      = 1'b0;
            n_phase       = PH_START;
            n_neg         = 1'b0;
            n_mag         = '0;
            n_first       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld      <= 1'b0;
            r_in_frame    <= 1'b0;
            r_count       <= '0;
            r_prefix_good <= 1'b1;
            r_text_ended  <= 1'b0;
            r_tok_num     <= 2'd0;
            r_inside      <= 1'b0;
            r_phase       <= PH_START;
            r_neg         <= 1'b0;
            r_mag         <= '0;
            r_first       <= '0;
            r_held_x      <= '0;
            r_held_y      <= '0;
            r_out_vld     <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_vld <= i_valid;
            end
            if (advance) begin
                r_in_frame    <= n_in_frame;
                r_count       <= n_count;
                r_prefix_good <= n_prefix_good;
                r_text_ended  <= n_text_ended;
                r_tok_num     <= n_tok_num;
                r_inside      <= n_inside;
                r_phase       <= n_phase;
                r_neg         <= n_neg;
                r_mag         <= n_mag;
                r_first       <= n_first;
                r_held_x      <= n_held_x;
                r_held_y      <= n_held_y;
            end
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // hold payload until taken
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (emit) begin
            r_out_status <= n_out_status;
            r_out_x      <= n_held_x;
            r_out_y      <= n_held_y;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_frame_status = r_out_status;
    assign o_pos_x        = r_out_x;
    assign o_pos_y        = r_out_y;

endmodule

`default_nettype wire
